### hw/rtl/timed_relay_output_controller_top_defines.svh
// Assertion macros for the timed relay output controller checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TIMED_RELAY_OUTPUT_CONTROLLER_TOP_DEFINES_SVH
`define TIMED_RELAY_OUTPUT_CONTROLLER_TOP_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define TRC_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define TRC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/trc_pkg.sv
// Shared types and constants of the timed relay output controller.
// No dependencies; used by every other file of the block but the assertion macro header.
package trc_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int REQ_W        = 3;
  localparam int DUR_W        = 12;
  localparam int CNT_W        = 16;
  localparam int ADDR_W       = 2;
  localparam int DATA_W       = 32;
  localparam int NODE_W       = 7;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [CNT_W-1:0] HOLD_COUNT   = 16'd32000;
  localparam logic [DUR_W-1:0] MAX_DURATION = 12'd3199;

  localparam logic [REQ_W-1:0] REQ_SET    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RESET  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TIMED  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;

  localparam logic [ADDR_W-1:0] ADDR_NODE = 2'd0;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_TOGGLE,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [CH_W-1:0]  ch;
    logic             lvl;
    logic [CNT_W-1:0] cnt;
  } op_t;

endpackage

### hw/rtl/trc_req_if.sv
// Request channel of the timed relay output controller.
// Depends on trc_pkg for field widths.
interface trc_req_if;
  logic                      valid;
  logic                      ready;
  logic [trc_pkg::REQ_W-1:0] req_type;
  logic [trc_pkg::CH_W-1:0]  channel;
  logic [trc_pkg::DUR_W-1:0] duration;

  modport source (output valid, output req_type, output channel, output duration,
                  input ready);
  modport sink (input valid, input req_type, input channel, input duration,
                output ready);
endinterface

### hw/rtl/trc_rpt_if.sv
// Report channel of the timed relay output controller.
// Depends on trc_pkg for field widths.
interface trc_rpt_if;
  logic                     valid;
  logic                     ready;
  logic [trc_pkg::CH_W-1:0] channel_res;
  logic                     level;
  logic                     last;

  modport source (output valid, output channel_res, output level, output last,
                  input ready);
  modport sink (input valid, input channel_res, input level, input last,
                output ready);
endinterface

### hw/rtl/trc_front.sv
// Front end: accepts request words, drops unknown ones, turns the rest into ops.
// Depends on trc_pkg and trc_req_if.
module trc_front (
  trc_req_if.sink       req,
  input  logic          q_full,
  output logic          push,
  output trc_pkg::op_t  push_op
);
  import trc_pkg::*;

  logic [CNT_W-1:0] timed_cnt;
  logic             known;

  assign req.ready = !q_full;

  // duration * 10 as two shifted adds
  assign timed_cnt = (CNT_W'(req.duration) << 3) + (CNT_W'(req.duration) << 1);

  always_comb begin
    push_op.kind = OP_WRITE;
    push_op.ch   = req.channel;
    push_op.lvl  = 1'b1;
    push_op.cnt  = HOLD_COUNT;
    known        = int'(req.channel) < NUM_CHANNELS;
    unique case (req.req_type)
      REQ_SET: begin
        push_op.kind = OP_WRITE;
      end
      REQ_RESET: begin
        push_op.lvl = 1'b0;
      end
      REQ_TOGGLE: begin
        push_op.kind = OP_TOGGLE;
      end
      REQ_TIMED: begin
        if (req.duration <= MAX_DURATION) begin
          push_op.cnt = timed_cnt;
        end
      end
      REQ_TICK: begin
        push_op.kind = OP_TICK;
        known        = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push = req.valid && req.ready && known;

endmodule

### hw/rtl/trc_queue.sv
// Short op queue between front end and back end.
// Depends on trc_pkg.
module trc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  trc_pkg::op_t push_op,
  output logic         full,
  output logic         q_valid,
  output trc_pkg::op_t q_op,
  input  logic         pop
);
  import trc_pkg::*;

  op_t            slots [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           do_pop;

  assign full    = count == (QAW+1)'(QDEPTH);
  assign q_valid = count != '0;
  assign q_op    = slots[rptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_op;
    end
  end

endmodule

### hw/rtl/trc_back.sv
// Back end: channel state, tick countdown and change report sequencing.
// Depends on trc_pkg and trc_rpt_if.
module trc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [trc_pkg::NODE_W-1:0] node_address,
  input  logic                      q_valid,
  input  trc_pkg::op_t              q_op,
  output logic                      pop,
  trc_rpt_if.source                 rpt
);
  import trc_pkg::*;

  function automatic logic [CH_W-1:0] lowest(input logic [NUM_CHANNELS-1:0] m);
    logic [CH_W-1:0] idx;
    idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = CH_W'(i);
      end
    end
    return idx;
  endfunction

  logic [CNT_W-1:0]        cnt      [NUM_CHANNELS];
  logic [CNT_W-1:0]        cnt_tick [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] lvl;
  logic [NUM_CHANNELS-1:0] lvl_tick;
  logic [NUM_CHANNELS-1:0] rep;
  logic [NUM_CHANNELS-1:0] pend;
  logic [NUM_CHANNELS-1:0] sel_oh;
  logic [CH_W-1:0]         sel;
  logic                    load;

  logic            out_valid;
  logic [CH_W-1:0] out_ch;
  logic            out_lvl;
  logic            out_last;

  // hold the queue while a tick still has reports to send
  assign pop = q_valid && (pend == '0);

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cnt_tick[i] = cnt[i];
      lvl_tick[i] = lvl[i];
      if (!cnt[i][CNT_W-1]) begin
        if (cnt[i] < HOLD_COUNT) begin
          cnt_tick[i] = cnt[i] - 1'b1;
        end
      end else begin
        lvl_tick[i] = 1'b0;
      end
    end
  end

  assign sel    = lowest(pend);
  assign sel_oh = NUM_CHANNELS'(1) << sel;
  assign load   = (pend != '0) && (!out_valid || rpt.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt[i] <= HOLD_COUNT;
      end
      lvl       <= '0;
      rep       <= '0;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        unique case (q_op.kind)
          OP_WRITE: begin
            cnt[q_op.ch] <= q_op.cnt;
            lvl[q_op.ch] <= q_op.lvl;
          end
          OP_TOGGLE: begin
            cnt[q_op.ch] <= HOLD_COUNT;
            lvl[q_op.ch] <= !lvl[q_op.ch];
          end
          OP_TICK: begin
            cnt <= cnt_tick;
            lvl <= lvl_tick;
            if (node_address != '0) begin
              pend <= lvl_tick ^ rep;
              rep  <= lvl_tick;
            end
          end
          default: begin
          end
        endcase
      end
      if (load) begin
        pend <= pend & ~sel_oh;
      end
      if (!out_valid || rpt.ready) begin
        out_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch   <= sel;
      out_lvl  <= lvl[sel];
      out_last <= (pend & ~sel_oh) == '0;
    end
  end

  assign rpt.valid       = out_valid;
  assign rpt.channel_res = out_ch;
  assign rpt.level       = out_lvl;
  assign rpt.last        = out_last;

endmodule

### hw/rtl/timed_relay_output_controller_top.sv
// Timed relay output controller: a command updates one channel; a tick holds the op queue
// until every change it found is reported. Requests are registered in the 4-entry op
// queue and enter at up to one per cycle while it has room; report words are registered.
// Back-end rate is set by the report sequencer, one report word per cycle while ready.
// Synchronous reset clears the queue, node address, levels, reported levels and
// sets every countdown to hold.
module timed_relay_output_controller_top (
  input  logic                        clk,
  input  logic                        rst,
  trc_req_if.sink                     req,
  trc_rpt_if.source                   rpt,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trc_pkg::ADDR_W-1:0]  paddr,
  input  logic [trc_pkg::DATA_W-1:0]  pwdata,
  output logic [trc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import trc_pkg::*;

  logic              push;
  op_t               push_op;
  logic              q_full;
  logic              q_valid;
  op_t               q_op;
  logic              pop;
  logic [NODE_W-1:0] node_address;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NODE) ? DATA_W'(node_address) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_NODE) begin
      node_address <= pwdata[NODE_W-1:0];
    end
  end

  trc_front u_front (
    .req     (req),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  trc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop)
  );

  trc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .node_address (node_address),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .pop          (pop),
    .rpt          (rpt)
  );

endmodule

### hw/rtl/trc_checker.sv
// Port-level checker for the timed relay output controller, bound to the top level.
// Depends on trc_pkg and timed_relay_output_controller_top_defines.svh.
`include "timed_relay_output_controller_top_defines.svh"

module trc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rpt_valid,
  input logic                       rpt_ready,
  input logic [trc_pkg::CH_W-1:0]   rpt_channel_res,
  input logic                       rpt_level,
  input logic                       rpt_last,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [trc_pkg::ADDR_W-1:0] paddr,
  input logic [trc_pkg::DATA_W-1:0] pwdata,
  input logic [trc_pkg::DATA_W-1:0] prdata
);
  import trc_pkg::*;

  // hold a stalled report word
  `TRC_ASSERT_RST(a_rpt_hold, clk, rst, rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt_channel_res) && $stable(rpt_level) && $stable(rpt_last), "report word changed while stalled")
  `TRC_ASSERT(a_rst_idle, clk, rst |=> !rpt_valid, "report valid after reset")
  // highest channel always closes the tick
  `TRC_ASSERT_RST(a_top_last, clk, rst, rpt_valid && rpt_channel_res == CH_W'(NUM_CHANNELS - 1) |-> rpt_last, "highest channel report not marked last")
  `TRC_ASSERT_RST(a_cfg_read, clk, rst, psel && penable && pwrite && paddr == ADDR_NODE |=> psel == 1'b0 || pwrite || paddr != ADDR_NODE || prdata == DATA_W'($past(pwdata[NODE_W-1:0])), "node address readback mismatch")

endmodule

bind timed_relay_output_controller_top trc_checker u_trc_checker (
  .clk             (clk),
  .rst             (rst),
  .rpt_valid       (rpt.valid),
  .rpt_ready       (rpt.ready),
  .rpt_channel_res (rpt.channel_res),
  .rpt_level       (rpt.level),
  .rpt_last        (rpt.last),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);

### tb/tb_top.sv
// Self-checking bench for timed_relay_output_controller_top: commands and ticks in, change reports out.
// Depends on trc_pkg, trc_req_if and trc_rpt_if; a scoreboard class predicts every report word.
module tb_top;
  import trc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = REQ_W'(REQ_TICK + 1);
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = {REQ_W{1'b1}};
  localparam logic [DUR_W-1:0] DUR_ALL_ONES     = {DUR_W{1'b1}};

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            lvl;
    logic            last;
  } report_t;

  class relay_scoreboard;
    int            countdown [NUM_CHANNELS];
    bit            out_on [NUM_CHANNELS];
    bit            reported_on [NUM_CHANNELS];
    bit [NODE_W-1:0] node_addr;
    report_t       pending_reports [$];
    int            errors;

    function new();
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        countdown[i]   = int'(HOLD_COUNT);
        out_on[i]      = 1'b0;
        reported_on[i] = 1'b0;
      end
      node_addr = '0;
      errors    = 0;
    endfunction

    function void set_node_address(bit [NODE_W-1:0] value);
      node_addr = value;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void run_tick();
      report_t batch [$];
      report_t word;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (countdown[i] >= 0) begin
          if (countdown[i] < int'(HOLD_COUNT))
            countdown[i]--;
        end else begin
          out_on[i] = 1'b0;
        end
      end
      if (node_addr == '0)
        return;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (out_on[i] != reported_on[i]) begin
          word.ch   = CH_W'(i);
          word.lvl  = out_on[i];
          word.last = 1'b0;
          batch.push_back(word);
          reported_on[i] = out_on[i];
        end
      end
      if (batch.size() > 0)
        batch[batch.size()-1].last = 1'b1;
      foreach (batch[k])
        pending_reports.push_back(batch[k]);
    endfunction

    function void note_request(logic [REQ_W-1:0] rt, logic [CH_W-1:0] ch,
                               logic [DUR_W-1:0] dur);
      if (rt == REQ_TICK) begin
        run_tick();
        return;
      end
      if (int'(ch) >= NUM_CHANNELS)
        return;
      case (rt)
        REQ_SET: begin
          countdown[ch] = int'(HOLD_COUNT);
          out_on[ch]    = 1'b1;
        end
        REQ_RESET: begin
          countdown[ch] = int'(HOLD_COUNT);
          out_on[ch]    = 1'b0;
        end
        REQ_TOGGLE: begin
          countdown[ch] = int'(HOLD_COUNT);
          out_on[ch]    = !out_on[ch];
        end
        REQ_TIMED: begin
          // saturate long durations to hold
          countdown[ch] = (dur > MAX_DURATION) ? int'(HOLD_COUNT) : int'(dur) * 10;
          out_on[ch]    = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_report(logic [CH_W-1:0] ch, logic lvl, logic last);
      report_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected report word: channel_res=%0d level=%0d last=%0d", ch, lvl, last);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (ch !== want.ch) begin
        $error("channel_res: expected %0d, got %0d", want.ch, ch);
        errors++;
      end
      if (lvl !== want.lvl) begin
        $error("level: expected %0d, got %0d", want.lvl, lvl);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  trc_req_if req_ch();
  trc_rpt_if rpt_ch();

  relay_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int quiet_cycles;

  timed_relay_output_controller_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch.sink),
    .rpt     (rpt_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rpt_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_OFF_CYCLES;
      rpt_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rpt_ch.ready <= 1'b0;
    end else begin
      rpt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check reports first, then fold in the accepted request
  always @(posedge clk) begin
    if (!rst) begin
      if (rpt_ch.valid && rpt_ch.ready)
        sb.check_report(rpt_ch.channel_res, rpt_ch.level, rpt_ch.last);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.req_type, req_ch.channel, req_ch.duration);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rpt_ch.valid && rpt_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timed_relay_output_controller_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] rt, input logic [CH_W-1:0] ch,
                              input logic [DUR_W-1:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.channel  <= ch;
    req_ch.duration <= dur;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // mostly short on-times so expiry shows up within the run
  function automatic logic [DUR_W-1:0] pick_duration();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65)
      return DUR_W'($urandom_range(2));
    else if (roll < 75)
      return DUR_W'($urandom_range(3, 20));
    else if (roll < 95)
      return DUR_W'($urandom_range(int'(DUR_ALL_ONES)));
    else
      return (roll < 97) ? MAX_DURATION : DUR_W'(MAX_DURATION + 1);
  endfunction

  task automatic send_random_request();
    int               roll;
    logic [REQ_W-1:0] rt;
    logic [DUR_W-1:0] dur;
    roll = $urandom_range(99);
    dur  = DUR_W'($urandom_range(int'(DUR_ALL_ONES)));
    if (roll < 40)
      rt = REQ_TICK;
    else if (roll < 50)
      rt = REQ_SET;
    else if (roll < 60)
      rt = REQ_RESET;
    else if (roll < 70)
      rt = REQ_TOGGLE;
    else if (roll < 95) begin
      rt  = REQ_TIMED;
      dur = pick_duration();
    end else begin
      rt = REQ_W'($urandom_range(int'(REQ_UNUSED_FIRST), int'(REQ_UNUSED_LAST)));
    end
    send_request(rt, CH_W'($urandom_range(NUM_CHANNELS - 1)), dur);
  endtask

  task automatic wait_for_reports();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_address(input logic [NODE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NODE;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read back through a second transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[NODE_W-1:0] !== value) begin
      $error("node_address: expected %0d, got %0d", value, prdata[NODE_W-1:0]);
      sb.errors++;
    end
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_node_address(value);
  endtask

  task automatic run_random_phase(input int count);
    for (int i = 0; i < count; i++)
      send_random_request();
  endtask

  initial begin
    rst             = 1'b1;
    hold_req        = 1'b0;
    send_idle_pct   = 7;
    recv_stall_pct  = 88;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_SET;
    req_ch.channel  <= '0;
    req_ch.duration <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= ADDR_NODE;
    pwdata          <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reports disabled at reset: levels move but nothing is reported
    send_request(REQ_SET, 2'd0, '0);
    send_request(REQ_TIMED, 2'd1, '0);
    send_request(REQ_TICK, 2'd0, '0);
    send_request(REQ_TICK, 2'd3, DUR_ALL_ONES);
    wait_for_reports();
    write_node_address(NODE_W'(1));

    // first enabled tick reports the difference left from the disabled ticks
    send_request(REQ_TICK, 2'd2, '0);
    send_request(REQ_SET, 2'd1, '0);
    send_request(REQ_SET, 2'd2, '0);
    send_request(REQ_SET, 2'd3, '0);
    send_request(REQ_TICK, 2'd0, '0);
    send_request(REQ_RESET, 2'd0, '0);
    send_request(REQ_TOGGLE, 2'd1, '0);
    send_request(REQ_TOGGLE, 2'd2, '0);
    send_request(REQ_TOGGLE, 2'd2, '0);
    send_request(REQ_TICK, 2'd1, '0);
    send_request(REQ_TIMED, 2'd3, MAX_DURATION);
    send_request(REQ_TIMED, 2'd2, DUR_ALL_ONES);
    send_request(REQ_TIMED, 2'd1, DUR_W'(MAX_DURATION + 1));
    send_request(REQ_TIMED, 2'd0, DUR_W'(1023));
    send_request(REQ_TIMED, 2'd0, '0);
    send_request(REQ_UNUSED_FIRST, 2'd3, DUR_ALL_ONES);
    send_request(REQ_W'(REQ_TICK + 2), 2'd0, DUR_ALL_ONES);
    send_request(REQ_UNUSED_LAST, 2'd1, '0);
    // expire channel 0, then force it off
    send_request(REQ_TICK, 2'd0, '0);
    send_request(REQ_TICK, 2'd0, '0);
    send_request(REQ_TICK, 2'd0, '0);
    wait_for_reports();

    write_node_address(NODE_W'(99));
    run_random_phase(150);
    wait_for_reports();

    send_idle_pct  = 88;
    recv_stall_pct = 7;
    write_node_address(NODE_W'(28));
    run_random_phase(150);
    wait_for_reports();

    write_node_address('0);
    run_random_phase(40);
    wait_for_reports();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_node_address(NODE_W'(1));
    // stall the report side while requests keep coming, so the queue fills
    hold_req <= 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_request(REQ_TOGGLE, CH_W'($urandom_range(NUM_CHANNELS - 1)), '0);
      send_request(REQ_TICK, '0, '0);
    end
    run_random_phase(100);
    wait_for_reports();

    if (sb.errors == 0)
      $display("timed_relay_output_controller_top: match");
    else
      $display("timed_relay_output_controller_top: mismatch");
    $finish;
  end

endmodule
